### hdl/ppiu_pkg.sv
package ppiu_pkg;

  localparam int WORD_W     = 64;
  localparam int IDX_W      = 16;
  localparam int CODE_W     = 2;
  localparam int PAL_W      = 17;
  localparam int CNT_W      = 25;
  localparam int WID_W      = 5;
  localparam int PER_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 25;

  // status codes
  localparam logic [CODE_W-1:0] STAT_OK         = 2'd0;
  localparam logic [CODE_W-1:0] STAT_INCOMPLETE = 2'd1;
  localparam logic [CODE_W-1:0] STAT_BAD_CFG    = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS = 1'd1;

  localparam logic [PAL_W-1:0] PALETTE_RESET = 17'd2;

  // one classified word, handed from the front to the back
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              fin;
    logic              bad;
    logic [WID_W-1:0]  width;
    logic [PER_W-1:0]  per;
    logic [IDX_W-1:0]  mask;
    logic [CNT_W-1:0]  total;
  } entry_t;

  // entry width: ceil(log2(pal)), clamped to 2..16
  function automatic logic [WID_W-1:0] width_of(input logic [PAL_W-1:0] pal);
    logic [PAL_W-1:0] v;
    logic [WID_W-1:0] b;
    v = pal - 17'd1;
    b = 5'd2;
    for (int i = 0; i < PAL_W; i++) begin
      if (v[i]) begin
        b = 5'(i + 1);
      end
    end
    if (pal <= 17'd1) begin
      b = 5'd2;
    end
    if (b < 5'd2) begin
      b = 5'd2;
    end
    if (b > 5'd16) begin
      b = 5'd16;
    end
    return b;
  endfunction

  // entries per 64-bit word
  function automatic logic [PER_W-1:0] per_of(input logic [WID_W-1:0] w);
    logic [PER_W-1:0] p;
    case (w)
      5'd2:    p = 6'd32;
      5'd3:    p = 6'd21;
      5'd4:    p = 6'd16;
      5'd5:    p = 6'd12;
      5'd6:    p = 6'd10;
      5'd7:    p = 6'd9;
      5'd8:    p = 6'd8;
      5'd9:    p = 6'd7;
      5'd10:   p = 6'd6;
      5'd11:   p = 6'd5;
      5'd12:   p = 6'd5;
      5'd13:   p = 6'd4;
      5'd14:   p = 6'd4;
      5'd15:   p = 6'd4;
      5'd16:   p = 6'd4;
      default: p = 6'd32;
    endcase
    return p;
  endfunction

endpackage

### hdl/ppiu_in_if.sv
interface ppiu_in_if;
  import ppiu_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] packed_word;
  logic              final_word;

  modport source (output valid, output packed_word, output final_word, input ready);
  modport sink   (input valid, input packed_word, input final_word, output ready);
endinterface

### hdl/ppiu_out_if.sv
interface ppiu_out_if;
  import ppiu_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  palette_index;
  logic              is_status;
  logic [CODE_W-1:0] status_code;
  logic              last_of_run;

  modport source (output valid, output palette_index, output is_status,
                  output status_code, output last_of_run, input ready);
  modport sink   (input valid, input palette_index, input is_status,
                  input status_code, input last_of_run, output ready);
endinterface

### hdl/ppiu_cfg_if.sv
interface ppiu_cfg_if;
  import ppiu_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/ppiu_front.sv
module ppiu_front #(
  parameter int MAX_BLOCKS = 16777216
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ppiu_in_if.sink                   in_ch,
  input  logic [ppiu_pkg::PAL_W-1:0] palette_size,
  input  logic [ppiu_pkg::CNT_W-1:0] total_blocks,
  input  logic                      push_ready,
  output logic                      push_valid,
  output ppiu_pkg::entry_t          push_entry
);
  import ppiu_pkg::*;

  localparam logic [30:0] MaxB = 31'(MAX_BLOCKS);

  logic             valid_r;
  entry_t           entry_r;
  entry_t           entry_nxt;
  logic [CNT_W-1:0] total_eff;
  logic [WID_W-1:0] width;
  logic [16:0]      mask_full;
  logic             accept;

  assign in_ch.ready = !valid_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_valid  = valid_r;
  assign push_entry  = entry_r;

  always_comb begin
    // saturate the total; a bound beyond the register range never hits
    if ({6'd0, total_blocks} > MaxB) begin
      total_eff = MaxB[CNT_W-1:0];
    end else begin
      total_eff = total_blocks;
    end
    width     = width_of(palette_size);
    mask_full = (17'd1 << width) - 17'd1;

    entry_nxt.fin   = in_ch.final_word;
    entry_nxt.bad   = (total_eff == '0) || (palette_size == '0);
    entry_nxt.width = width;
    entry_nxt.per   = per_of(width);
    entry_nxt.mask  = mask_full[IDX_W-1:0];
    entry_nxt.total = total_eff;
    // single-entry palette reads as all zeros
    entry_nxt.word  = (palette_size == 17'd1) ? '0 : in_ch.packed_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (push_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

### hdl/ppiu_fifo.sv
module ppiu_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  ppiu_pkg::entry_t push_entry,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output ppiu_pkg::entry_t pop_entry
);
  import ppiu_pkg::*;

  entry_t     mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### hdl/ppiu_back.sv
module ppiu_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fifo_valid,
  input  ppiu_pkg::entry_t fifo_entry,
  output logic             fifo_pop,
  ppiu_out_if.source       out_ch
);
  import ppiu_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic              fin_r;
  logic              bad_r;
  logic [WID_W-1:0]  width_r;
  logic [IDX_W-1:0]  mask_r;
  logic [CNT_W-1:0]  total_r;
  logic [PER_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              is_status_r, is_status_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              last_r, last_nxt;

  logic              slot_free;
  logic              more;
  logic              more_after;
  logic [CNT_W:0]    cnt_inc;
  logic              emit;

  assign fifo_pop  = (state_r == S_IDLE) && fifo_valid;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign cnt_inc   = {1'b0, cnt_r} + 26'd1;
  assign more      = !bad_r && (rem_r != '0) && (cnt_r < total_r);
  assign more_after = (rem_r > 6'd1) && (cnt_inc < {1'b0, total_r});

  assign out_ch.valid         = out_valid_r;
  assign out_ch.palette_index = idx_r;
  assign out_ch.is_status     = is_status_r;
  assign out_ch.status_code   = code_r;
  assign out_ch.last_of_run   = last_r;

  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    emit          = 1'b0;
    idx_nxt       = idx_r;
    is_status_nxt = is_status_r;
    code_nxt      = code_r;
    last_nxt      = last_r;

    unique case (state_r)
      S_IDLE: begin
        if (fifo_valid) begin
          state_nxt = S_RUN;
          word_nxt  = fifo_entry.word;
          rem_nxt   = fifo_entry.per;
        end
      end
      S_RUN: begin
        if (slot_free) begin
          if (more) begin
            emit          = 1'b1;
            idx_nxt       = word_r[IDX_W-1:0] & mask_r;
            is_status_nxt = 1'b0;
            code_nxt      = STAT_OK;
            last_nxt      = !more_after && !fin_r;
            word_nxt      = word_r >> width_r;
            rem_nxt       = rem_r - 6'd1;
            cnt_nxt       = cnt_inc[CNT_W-1:0];
            if (!more_after && !fin_r) begin
              state_nxt = S_IDLE;
            end
          end else if (fin_r) begin
            emit          = 1'b1;
            idx_nxt       = '0;
            is_status_nxt = 1'b1;
            last_nxt      = 1'b1;
            if (bad_r) begin
              code_nxt = STAT_BAD_CFG;
            end else if (cnt_r == total_r) begin
              code_nxt = STAT_OK;
            end else begin
              code_nxt = STAT_INCOMPLETE;
            end
            cnt_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            // count already reached or config bad, and not final: word gives nothing
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r      <= word_nxt;
    rem_r       <= rem_nxt;
    idx_r       <= idx_nxt;
    is_status_r <= is_status_nxt;
    code_r      <= code_nxt;
    last_r      <= last_nxt;
    if (fifo_pop) begin
      fin_r   <= fifo_entry.fin;
      bad_r   <= fifo_entry.bad;
      width_r <= fifo_entry.width;
      mask_r  <= fifo_entry.mask;
      total_r <= fifo_entry.total;
    end
  end

endmodule

### hdl/packed_palette_index_unpacker.sv
// channel  | port    | direction | payload
// ---------+---------+-----------+---------------------------------------------------
// input    | in_ch   | sink      | packed_word[63:0], final_word
// result   | out_ch  | source    | palette_index[15:0], is_status, status_code[1:0],
//          |         |           | last_of_run
// config   | cfg_ch  | sink      | index[0] (0 palette_size, 1 total_blocks), data[24:0]
//
// a word is held in the front register, then in the two-entry queue; the back loads it
// in its idle state and then gives one result per cycle while the output is not stalled
// (up to 33 results, or none); the back's one-result-per-cycle unpacker sets the rate
// synchronous active-low reset: palette_size 2, total_blocks 0, decoded count 0
// a stalled output holds the back; the front register and a two-entry queue keep
// taking up to three words meanwhile; config writes are always taken
module packed_palette_index_unpacker #(
  parameter int MAX_BLOCKS = 16777216
) (
  input  logic        clk,
  input  logic        rst_n,
  ppiu_in_if.sink     in_ch,
  ppiu_out_if.source  out_ch,
  ppiu_cfg_if.sink    cfg_ch
);
  import ppiu_pkg::*;

  logic [PAL_W-1:0] palette_size_r;
  logic [CNT_W-1:0] total_blocks_r;

  logic             push_valid;
  logic             push_ready;
  entry_t           push_entry;
  logic             pop;
  logic             pop_valid;
  entry_t           pop_entry;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_size_r <= PALETTE_RESET;
      total_blocks_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_PALETTE_SIZE: palette_size_r <= cfg_ch.data[PAL_W-1:0];
        REG_TOTAL_BLOCKS: total_blocks_r <= cfg_ch.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  ppiu_front #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .palette_size (palette_size_r),
    .total_blocks (total_blocks_r),
    .push_ready   (push_ready),
    .push_valid   (push_valid),
    .push_entry   (push_entry)
  );

  ppiu_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  ppiu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_valid (pop_valid),
    .fifo_entry (pop_entry),
    .fifo_pop   (pop),
    .out_ch     (out_ch)
  );

endmodule

### bench/tb_packed_palette_index_unpacker.sv
module tb_packed_palette_index_unpacker;
  import ppiu_pkg::*;

  localparam int unsigned MAX_BLOCKS = 16777216;
  localparam int DRAIN_CYCLES = 48;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_BURST = 6;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_WORDS = 220;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic              st;
    logic [CODE_W-1:0] code;
    logic              last;
  } unpacked_t;

  // one directed transaction, with an optional register update before it
  typedef struct packed {
    bit                set_cfg;
    bit [PAL_W-1:0]    pal;
    bit [CNT_W-1:0]    tot;
    bit [WORD_W-1:0]   word;
    bit                fin;
    bit                typed;
    bit [5:0]          exp_n;
    bit [CODE_W-1:0]   exp_code;
  } word_row_t;

  localparam int DIR_N = 23;
  localparam word_row_t WORD_ROWS [DIR_N] = '{
    '{1'b0, 17'd0, 25'd0, 64'h0, 1'b1, 1'b1, 6'd1, STAT_BAD_CFG},
    '{1'b0, 17'd0, 25'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 6'd0, STAT_OK},
    '{1'b1, 17'd2, 25'd32, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 6'd33, STAT_OK},
    '{1'b1, 17'd2, 25'd40, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 6'd0, STAT_OK},
    '{1'b0, 17'd0, 25'd0, 64'hFEDC_BA98_7654_3210, 1'b1, 1'b0, 6'd0, STAT_OK},
    '{1'b1, 17'd1, 25'd5, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 6'd6, STAT_OK},
    '{1'b1, 17'd0, 25'd5, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 6'd1, STAT_BAD_CFG},
    '{1'b1, 17'd2, 25'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 6'd1, STAT_BAD_CFG},
    '{1'b1, 17'd65536, 25'd4, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 6'd5, STAT_OK},
    '{1'b1, 17'd131071, 25'd8, 64'h8000_7FFF_0001_FFFE, 1'b0, 1'b0, 6'd0, STAT_OK},
    '{1'b0, 17'd0, 25'd0, 64'hA5A5_5A5A_C3C3_3C3C, 1'b1, 1'b0, 6'd0, STAT_OK},
    '{1'b1, 17'd3, 25'h1FF_FFFF, 64'h5555_5555_5555_5555, 1'b1, 1'b1, 6'd33,
      STAT_INCOMPLETE},
    '{1'b1, 17'd2, 25'h100_0000, 64'h0, 1'b1, 1'b1, 6'd33, STAT_INCOMPLETE},
    '{1'b1, 17'd5, 25'd3, 64'h0F1E_2D3C_4B5A_6978, 1'b0, 1'b1, 6'd3, STAT_OK},
    '{1'b0, 17'd0, 25'd0, 64'h1234_5678_9ABC_DEF0, 1'b0, 1'b1, 6'd0, STAT_OK},
    '{1'b0, 17'd0, 25'd0, 64'h0FED_CBA9_8765_4321, 1'b1, 1'b1, 6'd1, STAT_OK},
    '{1'b1, 17'd16, 25'd20, 64'hFEDC_BA98_7654_3210, 1'b0, 1'b0, 6'd0, STAT_OK},
    '{1'b1, 17'd16, 25'd10, 64'h1111_2222_3333_4444, 1'b1, 1'b1, 6'd1, STAT_INCOMPLETE},
    '{1'b1, 17'd17, 25'd12, 64'h9876_5432_10FE_DCBA, 1'b1, 1'b1, 6'd13, STAT_OK},
    '{1'b1, 17'd1025, 25'd100, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 6'd6,
      STAT_INCOMPLETE},
    '{1'b1, 17'd2, 25'd1, 64'h0, 1'b1, 1'b1, 6'd2, STAT_OK},
    '{1'b1, 17'd4097, 25'd7, 64'hDEAD_BEEF_CAFE_F00D, 1'b0, 1'b0, 6'd0, STAT_OK},
    '{1'b0, 17'd0, 25'd0, 64'h0123_3210_4567_7654, 1'b1, 1'b0, 6'd0, STAT_OK}
  };

  logic clk = 1'b0;
  logic rst_n;

  ppiu_in_if  in_if();
  ppiu_out_if out_if();
  ppiu_cfg_if cfg_if();

  packed_palette_index_unpacker #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the block's registers and count
  logic [PAL_W-1:0] pal_reg;
  logic [CNT_W-1:0] total_reg;
  logic [CNT_W-1:0] emitted_cnt;

  unpacked_t pending_idx[$];
  int mismatches = 0;
  int words_sent = 0;
  int hold_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit held = 1'b0;
  bit paused = 1'b0;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int unsigned index_bits(input logic [PAL_W-1:0] pal);
    int unsigned b;
    logic [PAL_W-1:0] v;
    b = 0;
    if (pal <= 1) begin
      return 2;
    end
    v = pal - 1'b1;
    while (v != 0) begin
      v = v >> 1;
      b++;
    end
    if (b < 2) b = 2;
    if (b > 16) b = 16;
    return b;
  endfunction

  function automatic logic [CNT_W-1:0] clamped_total();
    return (total_reg > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : total_reg;
  endfunction

  // works out the results of one accepted word and queues them
  function automatic void unpack_expected(input logic [WORD_W-1:0] w, input logic f,
                                          output int n, output logic [CODE_W-1:0] code);
    logic [CNT_W-1:0] lim;
    bit bad;
    int unsigned wid;
    int unsigned per;
    int unsigned j;
    logic [WORD_W-1:0] mask;
    unpacked_t r;
    n = 0;
    code = STAT_OK;
    lim = clamped_total();
    bad = (lim == 0) || (pal_reg == 0);
    if (!bad) begin
      wid = index_bits(pal_reg);
      per = WORD_W / wid;
      mask = (64'd1 << wid) - 64'd1;
      for (j = 0; j < per && emitted_cnt < lim; j++) begin
        r.idx = (pal_reg > 1) ? IDX_W'((w >> (j * wid)) & mask) : '0;
        r.st = 1'b0;
        r.code = STAT_OK;
        r.last = 1'b0;
        pending_idx.push_back(r);
        n++;
        emitted_cnt = emitted_cnt + 1'b1;
      end
    end
    if (f) begin
      if (bad) code = STAT_BAD_CFG;
      else if (emitted_cnt == lim) code = STAT_OK;
      else code = STAT_INCOMPLETE;
      r.idx = '0;
      r.st = 1'b1;
      r.code = code;
      r.last = 1'b0;
      pending_idx.push_back(r);
      n++;
      emitted_cnt = '0;
    end
    if (n > 0) begin
      r = pending_idx.pop_back();
      r.last = 1'b1;
      pending_idx.push_back(r);
    end
  endfunction

  task automatic idle_in(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
  endtask

  task automatic send_word(input logic [WORD_W-1:0] w, input logic f,
                           output int n, output logic [CODE_W-1:0] code);
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.packed_word <= w;
    in_if.final_word <= f;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    unpack_expected(w, f, n, code);
  endtask

  // random gaps, plus the one-off hold-off and pause
  task automatic offer_word(input logic [WORD_W-1:0] w, input logic f,
                            output int n, output logic [CODE_W-1:0] code);
    if (!held && words_sent >= 80) begin
      held = 1'b1;
      hold_left = HOLD_CYCLES;
      // final words always give a status result, so the block backs up
      repeat (HOLD_BURST) begin
        send_word({$urandom, $urandom}, 1'b1, n, code);
        words_sent++;
      end
    end
    if (!paused && words_sent >= 150) begin
      paused = 1'b1;
      idle_in(1);
      while (pending_idx.size() != 0) @(posedge clk);
    end
    quiet = (words_sent >= 210);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      idle_in($urandom_range(1, 5));
    end
    send_word(w, f, n, code);
    words_sent++;
  endtask

  task automatic wait_idle();
    idle_in(1);
    while (pending_idx.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    if (idx == REG_PALETTE_SIZE) pal_reg = data[PAL_W-1:0];
    else total_reg = data[CNT_W-1:0];
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_config(input logic [PAL_W-1:0] pal, input logic [CNT_W-1:0] tot);
    wait_idle();
    write_reg(REG_PALETTE_SIZE, CFG_DATA_W'(pal));
    write_reg(REG_TOTAL_BLOCKS, CFG_DATA_W'(tot));
  endtask

  task automatic run_array();
    int unsigned per;
    int unsigned rem;
    int unsigned nw;
    int unsigned cut;
    int kind;
    int n;
    logic [CODE_W-1:0] code;
    per = WORD_W / index_bits(pal_reg);
    rem = (clamped_total() > emitted_cnt) ? int'(clamped_total() - emitted_cnt) : 0;
    nw = (rem == 0) ? 1 : (rem + per - 1) / per;
    if (nw > 6) nw = 6;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      for (int i = 0; i < nw; i++) begin
        offer_word({$urandom, $urandom}, i == nw - 1, n, code);
      end
    end else if (kind == 7) begin
      // final word comes early
      cut = (nw > 1) ? $urandom_range(1, nw - 1) : 1;
      for (int i = 0; i < cut; i++) begin
        offer_word({$urandom, $urandom}, i == cut - 1, n, code);
      end
    end else if (kind == 8) begin
      // extra words beyond the word count for the total (at most six) before the final one
      cut = nw + $urandom_range(1, 2);
      for (int i = 0; i <= cut; i++) begin
        offer_word({$urandom, $urandom}, i == cut, n, code);
      end
    end else begin
      offer_word({$urandom, $urandom}, 1'($urandom_range(0, 1)), n, code);
    end
  endtask

  // result side: random stalls, the long hold-off, none at the end
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_if.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
    end
  end

  always @(posedge clk) begin
    unpacked_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_idx.size() == 0) begin
        report_mismatch("result with none pending", out_if.palette_index, 0);
      end else begin
        want = pending_idx.pop_front();
        if (out_if.palette_index !== want.idx)
          report_mismatch("palette_index", out_if.palette_index, want.idx);
        if (out_if.is_status !== want.st)
          report_mismatch("is_status", out_if.is_status, want.st);
        if (out_if.status_code !== want.code)
          report_mismatch("status_code", out_if.status_code, want.code);
        if (out_if.last_of_run !== want.last)
          report_mismatch("last_of_run", out_if.last_of_run, want.last);
      end
    end
  end

  // cycles without any transaction on any channel
  always @(posedge clk) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
        (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** packed_palette_index_unpacker: FAILED **");
      $finish;
    end
  end

  initial begin
    int n;
    logic [CODE_W-1:0] code;
    logic [PAL_W-1:0] pal;
    logic [CNT_W-1:0] tot;
    int k;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.packed_word = '0;
    in_if.final_word = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_PALETTE_SIZE;
    cfg_if.data = '0;
    pal_reg = PALETTE_RESET;
    total_reg = '0;
    emitted_cnt = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (WORD_ROWS[i]) begin
      if (WORD_ROWS[i].set_cfg) set_config(WORD_ROWS[i].pal, WORD_ROWS[i].tot);
      offer_word(WORD_ROWS[i].word, WORD_ROWS[i].fin, n, code);
      if (WORD_ROWS[i].typed) begin
        if (n != WORD_ROWS[i].exp_n)
          report_mismatch($sformatf("row %0d result count", i), n, WORD_ROWS[i].exp_n);
        if (WORD_ROWS[i].fin && code != WORD_ROWS[i].exp_code)
          report_mismatch($sformatf("row %0d status", i), code, WORD_ROWS[i].exp_code);
      end
    end

    while (words_sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 11))
        0:       pal = '0;
        1:       pal = 17'd1;
        2:       pal = 17'd131071;
        3:       pal = 17'd65536;
        default: begin
          k = $urandom_range(1, 16);
          pal = PAL_W'($urandom_range(2, 32'd1 << k));
        end
      endcase
      case ($urandom_range(0, 9))
        0:       tot = '0;
        1:       tot = CNT_W'($urandom_range(16777216, 33554431));
        2:       tot = CNT_W'($urandom_range(81, 400));
        default: tot = CNT_W'($urandom_range(1, 80));
      endcase
      set_config(pal, tot);
      repeat ($urandom_range(1, 4)) run_array();
    end

    idle_in(1);
    while (pending_idx.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** packed_palette_index_unpacker: PASSED **");
    end else begin
      $display("** packed_palette_index_unpacker: FAILED **");
    end
    $finish;
  end

endmodule
